// File: hdl/hbfd_pkg.sv
// Package for the home bus frame deframer: sizes, frame constants,
// sequencer state type and the circular buffer index wrap helper.
// No dependencies.
`default_nettype none

package hbfd_pkg;

	// Receive buffer depth in bytes (21 to 32)
	localparam int BUF_BYTES = 21;
	localparam int IDX_W     = $clog2(BUF_BYTES);
	localparam int FILL_W    = $clog2(BUF_BYTES + 1);
	localparam int SUM_W     = FILL_W + 1;

	// Frame layout constants
	localparam logic [7:0] SOF_BYTE   = 8'h0f;
	localparam logic [7:0] PRIO_MASK  = 8'hfc;
	localparam logic [7:0] PRIO_TAG   = 8'hf8;
	localparam logic [7:0] HDR_MASK   = 8'hb0;
	localparam logic [7:0] EOF_BYTE   = 8'h04;
	localparam logic [7:0] BTN_TYPE   = 8'h00;
	localparam logic [3:0] BTN_LEN    = 4'd4;
	localparam int         MIN_FRAME  = 6;
	localparam int         DATA_START = 4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_RD,
		ST_CHK,
		ST_EMIT_RD,
		ST_EMIT_LD,
		ST_DROP
	} state_t;

	// Fold a position below twice the depth back into the buffer
	function automatic logic [IDX_W-1:0] wrap_idx(input logic [SUM_W-1:0] pos);
		logic [SUM_W-1:0] adj;
		adj = (pos >= SUM_W'(BUF_BYTES)) ? pos - SUM_W'(BUF_BYTES) : pos;
		return adj[IDX_W-1:0];
	endfunction

endpackage

`default_nettype wire

// File: hdl/hbfd_if.sv
// Valid/ready channel interfaces of the home bus frame deframer:
// received byte channel and decoded result channel. No dependencies.
`default_nettype none

interface hbfd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface hbfd_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] priority_res;
	logic [7:0] node_address;
	logic       remote_request;
	logic [3:0] data_length;
	logic [3:0] byte_index;
	logic [7:0] payload_byte;
	logic       has_byte;
	logic       message_kind;
	logic       last_of_frame;

	modport source (output valid, output priority_res, output node_address,
		output remote_request, output data_length, output byte_index,
		output payload_byte, output has_byte, output message_kind,
		output last_of_frame, input ready);
	modport sink (input valid, input priority_res, input node_address,
		input remote_request, input data_length, input byte_index,
		input payload_byte, input has_byte, input message_kind,
		input last_of_frame, output ready);
endinterface

`default_nettype wire

// File: hdl/home_bus_frame_deframer_core.sv
// Home bus frame deframer: circular receive buffer, byte-serial frame checker
// and result output register. Depends on hbfd_pkg and hbfd_if.sv.
// Each buffered byte examined passes through a read state and a check state
// (ST_RD, ST_CHK); a good frame is then emitted from the buffer result by result.
// New bytes are accepted only while the sequencer is idle, so no byte is taken
// while a frame is checked or emitted. Reset: empty, idle.
`default_nettype none

module home_bus_frame_deframer_core (
	input  wire logic     clk,
	input  wire logic     arst_n,
	hbfd_rx_if.sink       rx,
	hbfd_res_if.source    result
);

	localparam int IDX_W = hbfd_pkg::IDX_W;
	localparam int FILL_W = hbfd_pkg::FILL_W;
	localparam int SUM_W = hbfd_pkg::SUM_W;

	hbfd_pkg::state_t state_q, state_d;

	// Control registers
	logic [IDX_W-1:0]  head_q;
	logic [FILL_W-1:0] fill_q;
	logic              out_valid_q;

	// Working registers
	logic [7:0]        mem_q [hbfd_pkg::BUF_BYTES];
	logic [7:0]        rdata_q;
	logic [IDX_W-1:0]  idx_q;
	logic [7:0]        sum_q;
	logic [1:0]        prio_q;
	logic [7:0]        addr_q;
	logic              rtr_q;
	logic [3:0]        len_q;
	logic [7:0]        first_q;
	logic              button_q;
	logic [3:0]        k_q;

	// Output register
	logic [1:0]        o_prio_q;
	logic [7:0]        o_addr_q;
	logic              o_rtr_q;
	logic [3:0]        o_len_q;
	logic [3:0]        o_idx_q;
	logic [7:0]        o_byte_q;
	logic              o_has_q;
	logic              o_kind_q;
	logic              o_last_q;

	// Combinational controls
	logic              rx_fire;
	logic              out_free;
	logic [IDX_W-1:0]  rd_off;
	logic [IDX_W-1:0]  rd_addr;
	logic [IDX_W-1:0]  wr_addr;
	logic              chk_err;
	logic              chk_wait;
	logic              chk_ok;
	logic              button_bad;
	logic [IDX_W-1:0]  ck_idx;
	logic [IDX_W-1:0]  eof_idx;
	logic [FILL_W-1:0] frame_len;
	logic [FILL_W-1:0] need_len;
	logic              emit_last;

	assign rx_fire  = rx.valid && rx.ready;
	assign out_free = !out_valid_q || result.ready;

	// Buffer positions
	assign ck_idx    = IDX_W'(hbfd_pkg::DATA_START) + IDX_W'(len_q);
	assign eof_idx   = ck_idx + IDX_W'(1);
	assign frame_len = FILL_W'(hbfd_pkg::MIN_FRAME) + FILL_W'(len_q);
	assign need_len  = FILL_W'(hbfd_pkg::MIN_FRAME) + FILL_W'(rdata_q[3:0]);
	assign wr_addr   = hbfd_pkg::wrap_idx(SUM_W'(head_q) + SUM_W'(fill_q));
	assign rd_addr   = hbfd_pkg::wrap_idx(SUM_W'(head_q) + SUM_W'(rd_off));
	assign emit_last = (len_q == 4'd0) || (4'(k_q + 4'd1) == len_q);

	// Push button frames carry a fixed form
	assign button_bad = (len_q != 4'd0) && (first_q == hbfd_pkg::BTN_TYPE) &&
		((prio_q != 2'd0) || rtr_q || (len_q != hbfd_pkg::BTN_LEN));

	// Per-byte check of the byte now in rdata_q
	always_comb begin
		chk_err  = 1'b0;
		chk_wait = 1'b0;
		chk_ok   = 1'b0;
		if (idx_q == IDX_W'(0)) begin
			chk_err = (rdata_q != hbfd_pkg::SOF_BYTE);
		end else if (idx_q == IDX_W'(1)) begin
			chk_err = ((rdata_q & hbfd_pkg::PRIO_MASK) != hbfd_pkg::PRIO_TAG);
		end else if (idx_q == IDX_W'(3)) begin
			chk_err  = ((rdata_q & hbfd_pkg::HDR_MASK) != 8'h00);
			chk_wait = !chk_err && (fill_q < need_len);
		end else if (idx_q == ck_idx) begin
			chk_err = (rdata_q != 8'(8'd0 - sum_q));
		end else if (idx_q == eof_idx) begin
			chk_err = (rdata_q != hbfd_pkg::EOF_BYTE) || button_bad;
			chk_ok  = !chk_err;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			hbfd_pkg::ST_IDLE: begin
				if (rx_fire) state_d = hbfd_pkg::ST_START;
			end
			hbfd_pkg::ST_START: begin
				if (fill_q < FILL_W'(hbfd_pkg::MIN_FRAME)) state_d = hbfd_pkg::ST_IDLE;
				else state_d = hbfd_pkg::ST_RD;
			end
			hbfd_pkg::ST_RD: state_d = hbfd_pkg::ST_CHK;
			hbfd_pkg::ST_CHK: begin
				if (chk_err) state_d = hbfd_pkg::ST_START;
				else if (chk_wait) state_d = hbfd_pkg::ST_IDLE;
				else if (chk_ok) state_d = hbfd_pkg::ST_EMIT_RD;
				else state_d = hbfd_pkg::ST_RD;
			end
			hbfd_pkg::ST_EMIT_RD: state_d = hbfd_pkg::ST_EMIT_LD;
			hbfd_pkg::ST_EMIT_LD: begin
				if (out_free) begin
					state_d = emit_last ? hbfd_pkg::ST_DROP : hbfd_pkg::ST_EMIT_RD;
				end
			end
			hbfd_pkg::ST_DROP: state_d = hbfd_pkg::ST_IDLE;
			default: state_d = hbfd_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		rx.ready = 1'b0;
		rd_off   = IDX_W'(hbfd_pkg::DATA_START) + IDX_W'(k_q);
		case (state_q)
			hbfd_pkg::ST_IDLE: rx.ready = 1'b1;
			hbfd_pkg::ST_RD:   rd_off = idx_q;
			default: begin
				rx.ready = 1'b0;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= hbfd_pkg::ST_IDLE;
			head_q      <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (rx_fire) begin
				// full buffer: new byte overwrites the oldest
				if (fill_q == FILL_W'(hbfd_pkg::BUF_BYTES)) begin
					head_q <= hbfd_pkg::wrap_idx(SUM_W'(head_q) + SUM_W'(1));
				end else begin
					fill_q <= fill_q + FILL_W'(1);
				end
			end else if (state_q == hbfd_pkg::ST_CHK && chk_err) begin
				head_q <= hbfd_pkg::wrap_idx(SUM_W'(head_q) + SUM_W'(1));
				fill_q <= fill_q - FILL_W'(1);
			end else if (state_q == hbfd_pkg::ST_DROP) begin
				head_q <= hbfd_pkg::wrap_idx(SUM_W'(head_q) + SUM_W'(frame_len));
				fill_q <= fill_q - frame_len;
			end
			if (state_q == hbfd_pkg::ST_EMIT_LD && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Buffer memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (rx_fire) mem_q[wr_addr] <= rx.rx_byte;
		rdata_q <= mem_q[rd_addr];
	end

	// Frame field capture and running checksum
	always_ff @(posedge clk) begin
		case (state_q)
			hbfd_pkg::ST_START: idx_q <= '0;
			hbfd_pkg::ST_CHK: begin
				idx_q <= idx_q + IDX_W'(1);
				sum_q <= (idx_q == IDX_W'(0)) ? rdata_q : 8'(sum_q + rdata_q);
				if (idx_q == IDX_W'(1)) prio_q <= rdata_q[1:0];
				if (idx_q == IDX_W'(2)) addr_q <= rdata_q;
				if (idx_q == IDX_W'(3)) begin
					len_q <= rdata_q[3:0];
					rtr_q <= rdata_q[6];
				end
				if (idx_q == IDX_W'(hbfd_pkg::DATA_START)) first_q <= rdata_q;
				button_q <= (len_q != 4'd0) && (first_q == hbfd_pkg::BTN_TYPE);
				k_q      <= '0;
			end
			hbfd_pkg::ST_EMIT_LD: begin
				if (out_free) k_q <= k_q + 4'd1;
			end
			default: begin
				k_q <= k_q;
			end
		endcase
	end

	// Result register load
	always_ff @(posedge clk) begin
		if (state_q == hbfd_pkg::ST_EMIT_LD && out_free) begin
			o_prio_q <= prio_q;
			o_addr_q <= addr_q;
			o_rtr_q  <= rtr_q;
			o_len_q  <= len_q;
			o_idx_q  <= k_q;
			o_byte_q <= (len_q == 4'd0) ? 8'h00 : rdata_q;
			o_has_q  <= (len_q != 4'd0);
			o_kind_q <= button_q;
			o_last_q <= emit_last;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.priority_res   = o_prio_q;
	assign result.node_address   = o_addr_q;
	assign result.remote_request = o_rtr_q;
	assign result.data_length    = o_len_q;
	assign result.byte_index     = o_idx_q;
	assign result.payload_byte   = o_byte_q;
	assign result.has_byte       = o_has_q;
	assign result.message_kind   = o_kind_q;
	assign result.last_of_frame  = o_last_q;

	// Checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(hbfd_pkg::BUF_BYTES))
		else $error("buffer fill above depth");

	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_q < IDX_W'(hbfd_pkg::BUF_BYTES))
		else $error("head index outside buffer");

	a_fill_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(rx_fire && fill_q < FILL_W'(hbfd_pkg::BUF_BYTES)) |=>
		(fill_q == $past(fill_q) + FILL_W'(1)))
		else $error("accepted byte not counted");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result.ready) |=> out_valid_q && $stable(o_byte_q))
		else $error("pending result overwritten");

endmodule

`default_nettype wire
